/* rtl/core/can_seg_pkg.sv */
// Shared types and constants for the CAN message segmenter.
// Used by the frame builder, the output queue and the top level; no dependencies.
package can_seg_pkg;

  localparam int unsigned ID_W        = 11;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FLEN_W      = 4;
  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned PAYLOAD_W   = FRAME_BYTES * BYTE_W;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [LEN_W-1:0]  MIN_MSG_LEN = 16'd6;
  localparam logic [FLEN_W-1:0] FULL_FILL   = 4'd8;
  localparam logic [FLEN_W-1:0] HDR_FILL    = 4'd2;

  // Output queue depth; it must hold the two frames one byte can produce.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_ID  = 2'd0,
    CFG_MIDDLE_ID = 2'd1,
    CFG_LAST_ID   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [ID_W-1:0]      frame_id;
    logic [FLEN_W-1:0]    frame_length;
    logic [PAYLOAD_W-1:0] frame_payload;
    logic                 message_end;
  } frame_t;

  // Frames produced by one byte, in order: first is used when count >= 1.
  typedef struct packed {
    logic [1:0] count;
    frame_t     first;
    frame_t     second;
  } push_t;

endpackage

/* rtl/core/can_seg_frame_builder.sv */
// Message state, frame assembly and identifier registers of the segmenter.
// Depends on can_seg_pkg; produces up to two frames per byte for the output queue.
module can_seg_frame_builder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [can_seg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [can_seg_pkg::ID_W-1:0]     cfg_wdata,
  input  logic                             byte_valid,
  input  logic [can_seg_pkg::BYTE_W-1:0]   data_byte,
  input  logic [can_seg_pkg::LEN_W-1:0]    message_length,
  output can_seg_pkg::push_t               push
);
  import can_seg_pkg::*;

  logic [ID_W-1:0]      first_id_r, middle_id_r, last_id_r;
  logic [PAYLOAD_W-1:0] buf_r, buf_nxt;
  logic [FLEN_W-1:0]    fill_r, fill_nxt;
  logic [LEN_W-1:0]     taken_r, taken_nxt;
  logic [LEN_W-1:0]     exp_r, exp_nxt;
  logic [BYTE_W-1:0]    sum_r, sum_nxt;
  logic                 in_msg_r, in_msg_nxt;
  logic                 first_pend_r, first_pend_nxt;

  logic                 start, work, full, done;
  logic [PAYLOAD_W-1:0] buf_base, buf_add, buf_keep, buf_csum;
  logic [FLEN_W-1:0]    fill_base, fill_add, fill_keep;
  logic [LEN_W-1:0]     taken_base, taken_add, exp_base;
  logic [BYTE_W-1:0]    sum_base, sum_add;
  logic                 first_pend_base, first_pend_keep;
  frame_t               data_frame, csum_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_id_r  <= '0;
      middle_id_r <= '0;
      last_id_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FIRST_ID:  first_id_r  <= cfg_wdata;
        CFG_MIDDLE_ID: middle_id_r <= cfg_wdata;
        CFG_LAST_ID:   last_id_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    start = byte_valid && !in_msg_r && (message_length >= MIN_MSG_LEN);
    work  = byte_valid && (in_msg_r || start);

    // A new message starts with the length, high byte first.
    if (start) begin
      buf_base        = {48'd0, message_length[7:0], message_length[15:8]};
      fill_base       = HDR_FILL;
      taken_base      = '0;
      exp_base        = message_length;
      sum_base        = '0;
      first_pend_base = 1'b1;
    end else begin
      buf_base        = buf_r;
      fill_base       = fill_r;
      taken_base      = taken_r;
      exp_base        = exp_r;
      sum_base        = sum_r;
      first_pend_base = first_pend_r;
    end

    // Bytes above the fill point are zero, so a lane write is enough.
    buf_add = buf_base;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (fill_base[2:0] == 3'(i)) begin
        buf_add[i*BYTE_W +: BYTE_W] = data_byte;
      end
    end
    fill_add  = fill_base + 4'd1;
    taken_add = taken_base + 16'd1;
    sum_add   = sum_base + data_byte;

    full = (fill_add >= FULL_FILL);
    data_frame.frame_id      = first_pend_base ? first_id_r : middle_id_r;
    data_frame.frame_length  = FULL_FILL;
    data_frame.frame_payload = buf_add;
    data_frame.message_end   = 1'b0;

    if (full) begin
      buf_keep        = '0;
      fill_keep       = '0;
      first_pend_keep = 1'b0;
    end else begin
      buf_keep        = buf_add;
      fill_keep       = fill_add;
      first_pend_keep = first_pend_base;
    end

    done = !first_pend_keep && (taken_add == exp_base);
    buf_csum = buf_keep;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (fill_keep[2:0] == 3'(i)) begin
        buf_csum[i*BYTE_W +: BYTE_W] = sum_add;
      end
    end
    csum_frame.frame_id      = last_id_r;
    csum_frame.frame_length  = {1'b0, fill_keep[2:0]} + 4'd1;
    csum_frame.frame_payload = buf_csum;
    csum_frame.message_end   = 1'b1;

    push.count  = 2'(work && full) + 2'(work && done);
    push.first  = full ? data_frame : csum_frame;
    push.second = csum_frame;

    if (!work) begin
      buf_nxt        = buf_r;
      fill_nxt       = fill_r;
      taken_nxt      = taken_r;
      exp_nxt        = exp_r;
      sum_nxt        = sum_r;
      in_msg_nxt     = in_msg_r;
      first_pend_nxt = first_pend_r;
    end else if (done) begin
      buf_nxt        = '0;
      fill_nxt       = '0;
      taken_nxt      = '0;
      exp_nxt        = '0;
      sum_nxt        = '0;
      in_msg_nxt     = 1'b0;
      first_pend_nxt = 1'b1;
    end else begin
      buf_nxt        = buf_keep;
      fill_nxt       = fill_keep;
      taken_nxt      = taken_add;
      exp_nxt        = exp_base;
      sum_nxt        = sum_add;
      in_msg_nxt     = 1'b1;
      first_pend_nxt = first_pend_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r        <= '0;
      fill_r       <= '0;
      taken_r      <= '0;
      exp_r        <= '0;
      sum_r        <= '0;
      in_msg_r     <= 1'b0;
      first_pend_r <= 1'b1;
    end else begin
      buf_r        <= buf_nxt;
      fill_r       <= fill_nxt;
      taken_r      <= taken_nxt;
      exp_r        <= exp_nxt;
      sum_r        <= sum_nxt;
      in_msg_r     <= in_msg_nxt;
      first_pend_r <= first_pend_nxt;
    end
  end

endmodule

/* rtl/core/can_seg_out_fifo.sv */
// Small output queue of finished frames; takes up to two frames per cycle.
// Depends on can_seg_pkg; the head entry drives the result channel directly.
module can_seg_out_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  can_seg_pkg::push_t    push,
  output logic                  room_for_two,
  output logic                  head_valid,
  input  logic                  head_pop,
  output can_seg_pkg::frame_t   head
);
  import can_seg_pkg::*;

  frame_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [QPTR_W-1:0]   wr_ptr_1;
  logic                pop;

  always_comb begin
    pop          = head_pop && (cnt_r != '0);
    wr_ptr_1     = wr_ptr_r + 1'b1;
    wr_ptr_nxt   = wr_ptr_r + QPTR_W'(push.count);
    rd_ptr_nxt   = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt      = cnt_r + QCNT_W'(push.count) - QCNT_W'(pop);
    room_for_two = (cnt_r <= QCNT_W'(QDEPTH - 2));
    head_valid   = (cnt_r != '0);
    head         = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/can_message_segmenter_unit.sv */
// Top level of the CAN message segmenter: input register, frame builder, output queue.
// Depends on can_seg_pkg, can_seg_frame_builder and can_seg_out_fifo.
//
// Usage: message bytes arrive one beat at a time on the in_ stream. The beat
// carries the data byte and the message length; the length is only looked at
// on the first byte of a message, and a first byte whose length is below six
// is dropped without any frame. Classic CAN frames leave on the out_ stream,
// one frame per beat, with out_tlast set on the frame that carries the
// modulo-256 checksum and closes the message. The user must write the three
// frame identifiers through the cfg_ port while idle; the block never checks.
//
// An accepted input beat waits in the input register; the frame builder's
// result then goes straight into the output queue, whose head drives
// out_tvalid. Throughput is one byte per cycle while the output queue has
// room for two frames; a byte that closes both a full frame and the message
// yields two frames, and since the result channel moves one frame per cycle,
// such a byte's frames leave there one after the other. The builder advances
// only when the four-entry output queue has room for two frames, so when the
// receiver stalls the queue fills, the input register holds and in_tready
// drops; nothing is lost. Reset clears the message state, the queue and the
// identifiers at once; the block is ready on the next cycle.
module can_message_segmenter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [can_seg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [can_seg_pkg::ID_W-1:0]      cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,  // data_byte[7:0], message_length[23:8]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [79:0]                       out_tdata, // frame_id[10:0], frame_length[14:11],
                                                       // frame_payload[78:15], zero[79]
  output logic                              out_tlast  // message_end
);
  import can_seg_pkg::*;

  // Input register: one beat waits here until the builder can take it.
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic [LEN_W-1:0]  in_len_r;
  logic              advance;
  logic              room_for_two;
  push_t             push;
  frame_t            head;

  assign advance   = in_valid_r && room_for_two;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata[7:0];
      in_len_r  <= in_tdata[23:8];
    end
  end

  can_seg_frame_builder u_builder (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .byte_valid     (advance),
    .data_byte      (in_byte_r),
    .message_length (in_len_r),
    .push           (push)
  );

  can_seg_out_fifo u_out_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .room_for_two (room_for_two),
    .head_valid   (out_tvalid),
    .head_pop     (out_tready),
    .head         (head)
  );

  assign out_tdata = {1'b0, head.frame_payload, head.frame_length, head.frame_id};
  assign out_tlast = head.message_end;

endmodule

/* test/tb.sv */
// Self-checking testbench for can_message_segmenter_unit: byte stream in, CAN frames out.
// Depends on can_seg_pkg and the RTL of the segmenter; the expected frames come from a
// behavioral predictor kept in this file, and every output beat is compared against it.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import can_seg_pkg::*;

  // Register index that the block must ignore.
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_IDX = 2'd3;

  // Cycles allowed after the last expected frame for beats that produce no frame.
  localparam int SETTLE_CYCLES = 8;
  // Accepted message bytes wanted from the random test.
  localparam int RANDOM_BEATS = 640;
  // Pick value for send_message that asks for random data bytes.
  localparam int RANDOM_BYTES = -1;
  // Length of the receiver hold-off in the backpressure test.
  localparam int HOLD_OFF_CYCLES = 300;
  // Bytes sent of the message with the largest length.
  localparam int LONG_PREFIX_BYTES = 30;
  // Absolute limit on the run, far above the slowest correct run.
  localparam longint TIMEOUT_NS = 64'd2_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ID_W-1:0]      cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;   // data_byte[7:0], message_length[23:8]
  logic                 out_tvalid;
  logic                 out_tready;
  logic [79:0]          out_tdata;  // frame_id[10:0], frame_length[14:11],
                                    // frame_payload[78:15], zero[79]
  logic                 out_tlast;  // message_end

  can_message_segmenter_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the segmenter: identifiers, the frame being
  // assembled, how many bytes of the message have been taken, the running
  // checksum and whether the first frame of the message is still to go out.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]      id_first, id_middle, id_last;
  logic [PAYLOAD_W-1:0] seg_buf;
  logic [FLEN_W-1:0]    seg_fill;
  logic [LEN_W-1:0]     seg_taken;
  logic [LEN_W-1:0]     seg_len;
  logic [BYTE_W-1:0]    seg_sum;
  logic                 seg_busy;
  logic                 seg_first_due;

  // Frames predicted but not yet seen on the output, oldest first.
  frame_t frames_due[$];

  // Bookkeeping for the summary and the verdict.
  int fail_count;
  int frames_checked;
  int bytes_consumed;
  int beats_dropped;
  int messages_sent;
  int input_stall_cycles;

  // Sender burst control; each step of hold_seq asks the receiver for one
  // long hold-off.
  int burst_left;
  bit no_gaps;
  int hold_seq;

  frame_t got_frame;
  frame_t want_frame;

  task automatic go_idle_model();
    seg_buf       = '0;
    seg_fill      = '0;
    seg_taken     = '0;
    seg_len       = '0;
    seg_sum       = '0;
    seg_busy      = 1'b0;
    seg_first_due = 1'b1;
  endtask

  task automatic push_frame(input logic [ID_W-1:0] id, input logic [FLEN_W-1:0] flen,
                            input logic [PAYLOAD_W-1:0] payload, input logic closes);
    frame_t f;
    f.frame_id      = id;
    f.frame_length  = flen;
    f.frame_payload = payload;
    f.message_end   = closes;
    frames_due.push_back(f);
  endtask

  // Works out the frames that one accepted input beat causes.
  task automatic predict_byte(input logic [BYTE_W-1:0] data, input logic [LEN_W-1:0] len);
    if (!seg_busy) begin
      // A first byte with a length below the minimum is dropped silently.
      if (len < MIN_MSG_LEN) begin
        beats_dropped++;
        return;
      end
      seg_len       = len;
      seg_buf       = '0;
      seg_buf[7:0]  = len[15:8];
      seg_buf[15:8] = len[7:0];
      seg_fill      = HDR_FILL;
      seg_taken     = '0;
      seg_sum       = '0;
      seg_busy      = 1'b1;
      seg_first_due = 1'b1;
    end
    seg_buf[8*seg_fill[2:0] +: 8] = data;
    seg_fill  = seg_fill + 1'b1;
    seg_taken = seg_taken + 1'b1;
    seg_sum   = seg_sum + data;
    bytes_consumed++;

    if (seg_fill == FULL_FILL) begin
      push_frame(seg_first_due ? id_first : id_middle, FULL_FILL, seg_buf, 1'b0);
      seg_buf       = '0;
      seg_fill      = '0;
      seg_first_due = 1'b0;
    end

    // The closing frame carries what is left plus the checksum byte; when the
    // data ended on a full frame it holds the checksum alone.
    if (!seg_first_due && seg_taken == seg_len) begin
      seg_buf[8*seg_fill[2:0] +: 8] = seg_sum;
      push_frame(id_last, seg_fill + 1'b1, seg_buf, 1'b1);
      go_idle_model();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offers one beat and returns right after the edge that accepts it. The
  // sender runs in bursts; between bursts valid may drop for a random gap.
  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic [LEN_W-1:0] len);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96)
                                               : $urandom_range(1, 16);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {len, data};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    predict_byte(data, len);
  endtask

  // Sends a whole message. Only the first beat carries the real length; the
  // others carry random lengths, which the block must ignore.
  task automatic send_message(input logic [LEN_W-1:0] len, input int byte_pick);
    logic [BYTE_W-1:0] data;
    for (int i = 0; i < len; i++) begin
      data = (byte_pick < 0) ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(byte_pick);
      send_byte(data, (i == 0) ? len : LEN_W'($urandom_range(0, 65535)));
    end
    messages_sent++;
  endtask

  // Stops offering, waits for every expected frame, then lets the pipeline
  // empty of beats that produce nothing.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the predictor takes the new value once the block has it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_FIRST_ID:  id_first  = value;
      CFG_MIDDLE_ID: id_middle = value;
      CFG_LAST_ID:   id_last   = value;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Short lengths on a first byte are dropped; identifiers are still at their
  // reset value of zero here.
  task automatic test_short_lengths();
    send_byte(8'hFF, 16'd0);
    send_byte(8'h00, MIN_MSG_LEN - 1'b1);
    settle();
  endtask

  // Minimum length: the first frame fills up on the sixth byte and a
  // checksum-only closing frame follows at once; all-ones data also makes the
  // checksum wrap. Length fourteen ends on a full middle frame the same way.
  task automatic test_boundary_lengths();
    send_message(MIN_MSG_LEN, 8'hFF);
    send_message(16'd14, RANDOM_BYTES);
    settle();
  endtask

  // Both extremes of the first and middle identifiers, the top value of the last
  // one, and a write to the unused index, which must change nothing.
  task automatic test_registers();
    write_reg(CFG_FIRST_ID, 11'h7FF);
    write_reg(CFG_MIDDLE_ID, 11'h7FF);
    write_reg(CFG_LAST_ID, 11'h7FF);
    write_reg(CFG_BAD_IDX, 11'h000);
    send_message(16'd22, RANDOM_BYTES);
    settle();
    write_reg(CFG_FIRST_ID, 11'h000);
    write_reg(CFG_MIDDLE_ID, 11'h000);
    write_reg(CFG_BAD_IDX, 11'h7FF);
    send_message(16'd13, 8'h00);
    settle();
    write_reg(CFG_FIRST_ID, 11'h123);
    write_reg(CFG_MIDDLE_ID, 11'h456);
    write_reg(CFG_LAST_ID, 11'h6AB);
  endtask

  // Identifiers changed while a message is part sent: frames that leave after
  // the write must carry the new values.
  task automatic test_register_change_mid_message();
    for (int i = 0; i < 10; i++)
      send_byte(BYTE_W'($urandom_range(0, 255)),
                (i == 0) ? 16'd40 : LEN_W'($urandom_range(0, 65535)));
    settle();
    write_reg(CFG_MIDDLE_ID, 11'h2C5);
    write_reg(CFG_LAST_ID, 11'h13A);
    for (int i = 10; i < 40; i++)
      send_byte(BYTE_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 65535)));
    messages_sent++;
    settle();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering back to back, so the output queue fills and in_tready drops.
  task automatic test_backpressure();
    no_gaps  = 1'b1;
    hold_seq = hold_seq + 1;
    for (int i = 0; i < 4; i++)
      send_message(16'd14 + i, RANDOM_BYTES);
    no_gaps = 1'b0;
    settle();
  endtask

  // Mostly short messages with random content, a few longer ones, noise bytes
  // with short lengths while idle, and identifier changes now and then.
  task automatic test_random_messages();
    int start;
    int pick;
    logic [LEN_W-1:0] len;
    logic [ID_W-1:0]  value;
    start = bytes_consumed;
    while (bytes_consumed - start < RANDOM_BEATS) begin
      if ($urandom_range(0, 7) == 0)
        send_byte(BYTE_W'($urandom_range(0, 255)),
                  LEN_W'($urandom_range(0, MIN_MSG_LEN - 1)));
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = LEN_W'($urandom_range(MIN_MSG_LEN, 24));
      else if (pick < 92) len = LEN_W'($urandom_range(25, 80));
      else                len = LEN_W'($urandom_range(81, 300));
      send_message(len, RANDOM_BYTES);
      if ($urandom_range(0, 9) == 0) begin
        settle();
        pick = $urandom_range(0, 3);
        value = (pick == 0) ? 11'h000 : (pick == 1) ? 11'h7FF
                                                    : ID_W'($urandom_range(0, 2047));
        write_reg(CFG_IDX_W'($urandom_range(0, 3)), value);
      end
    end
    settle();
  endtask

  // The largest length the field allows: the first frame carries all-ones in
  // both length bytes and middle frames follow. Only the opening part of the
  // message is sent, so it is still open when the run ends.
  task automatic test_longest_message();
    for (int i = 0; i < LONG_PREFIX_BYTES; i++)
      send_byte(BYTE_W'($urandom_range(0, 255)),
                (i == 0) ? 16'hFFFF : LEN_W'($urandom_range(0, 65535)));
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready runs of random length broken by short stalls, plus the
  // long hold-off that a test can ask for.
  // ---------------------------------------------------------------------------
  initial begin
    int ready_left;
    int stall_left;
    int hold_left;
    int hold_seen;
    ready_left = 0;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (ready_left > 0) begin
        out_tready <= 1'b1;
        ready_left--;
      end else begin
        ready_left = $urandom_range(1, 30);
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        out_tready <= (stall_left == 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame checker: every output beat is compared with the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected id %0h len %0d payload %h last %b",
               $realtime, what, want_frame.frame_id, want_frame.frame_length,
               want_frame.frame_payload, want_frame.message_end);
      $display("    got id %0h len %0d payload %h last %b pad %b",
               got_frame.frame_id, got_frame.frame_length, got_frame.frame_payload,
               got_frame.message_end, out_tdata[79]);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_tready) input_stall_cycles++;
      if (out_tvalid && out_tready) begin
        got_frame.frame_id      = out_tdata[10:0];
        got_frame.frame_length  = out_tdata[14:11];
        got_frame.frame_payload = out_tdata[78:15];
        got_frame.message_end   = out_tlast;
        frames_checked++;
        if (frames_due.size() == 0) begin
          want_frame = '0;
          report_failure("frame with none expected");
        end else begin
          want_frame = frames_due.pop_front();
          if (got_frame !== want_frame || out_tdata[79] !== 1'b0)
            report_failure("frame mismatch");
        end
      end
    end
  end

  // Hard limit on the run.
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d frames still expected", frames_due.size());
    $display("can_message_segmenter_unit regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset once, then the tests in turn, then the verdict.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_tvalid          = 1'b0;
    in_tdata           = '0;
    fail_count         = 0;
    frames_checked     = 0;
    bytes_consumed     = 0;
    beats_dropped      = 0;
    messages_sent      = 0;
    input_stall_cycles = 0;
    burst_left         = 0;
    no_gaps            = 1'b0;
    hold_seq           = 0;
    id_first           = '0;
    id_middle          = '0;
    id_last            = '0;
    go_idle_model();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_lengths();
    test_boundary_lengths();
    test_registers();
    test_register_change_mid_message();
    test_backpressure();
    test_random_messages();
    test_longest_message();

    $display("Run covered %0d messages from %0d data bytes, %0d short-length bytes dropped.",
             messages_sent, bytes_consumed, beats_dropped);
    $display("%0d frames checked, input held off for %0d cycles, %0d failures.",
             frames_checked, input_stall_cycles, fail_count);
    if (fail_count == 0)
      $display("can_message_segmenter_unit regression: pass");
    else
      $display("can_message_segmenter_unit regression: fail");
    $finish;
  end

endmodule
